// ===== sv/adms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adms_pkg
// Shared widths, register indexes and helpers for the depth-first order core.
// ----------------------------------------------------------------------------
package adms_pkg;

  localparam int GRAPH_SIDE  = 8;
  localparam int NODE_W      = 3;
  localparam int LABEL_W     = 8;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int NODE_COUNT_DEFAULT = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ADJACENCY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LABELS    = 1'd1;

  // start request handed from the front queue to the walker
  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
  } walk_req_t;

  function automatic logic [GRAPH_SIDE-1:0] adj_row(input logic [CFG_W-1:0] adj,
                                                    input logic [NODE_W-1:0] node);
    adj_row = adj[{node, 3'b000} +: GRAPH_SIDE];
  endfunction

  function automatic logic [LABEL_W-1:0] label_of(input logic [CFG_W-1:0] labels,
                                                  input logic [NODE_W-1:0] node);
    label_of = labels[{node, 3'b000} +: LABEL_W];
  endfunction

endpackage

// ===== sv/adms_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adms_start_if / adms_result_if
// Valid/ready channels carrying start nodes in and preorder results out.
// ----------------------------------------------------------------------------
interface adms_start_if import adms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] start_node;

  modport source (output valid, output start_node, input ready);
  modport sink   (input valid, input start_node, output ready);
endinterface

interface adms_result_if import adms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NODE_W-1:0]  node_index;
  logic [LABEL_W-1:0] node_label;
  logic               last_of_walk;

  modport source (output valid, output node_index, output node_label,
                  output last_of_walk, input ready);
  modport sink   (input valid, input node_index, input node_label,
                  input last_of_walk, output ready);
endinterface

// ===== sv/adms_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adms_front
// Two-entry queue of start nodes in front of the walker.
// ----------------------------------------------------------------------------
module adms_front import adms_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  adms_start_if.sink        in_ch,
  input  logic              req_pop,
  output walk_req_t         req
);

  logic [NODE_W-1:0] slot_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              push;
  logic              pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = req_pop && (cnt_r != 2'd0);

  assign req.valid = (cnt_r != 2'd0);
  assign req.node  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_ch.start_node;
    end
  end

endmodule

// ===== sv/adms_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adms_walk
// Depth-first walker: node stack, visited set and one-deep result hold-back.
// ----------------------------------------------------------------------------
module adms_walk import adms_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CFG_W-1:0]  adj,
  input  logic [CFG_W-1:0]  labels,
  input  walk_req_t         req,
  output logic              req_pop,
  adms_result_if.source     out_ch
);

  logic                  busy_r, busy_nxt;
  logic [NODE_COUNT-1:0] visited_r, visited_nxt;
  logic [NODE_W-1:0]     stack_r [GRAPH_SIDE];
  logic [NODE_W:0]       depth_r, depth_nxt;
  logic [NODE_W-1:0]     pend_node_r, pend_node_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]     out_node_r;
  logic [LABEL_W-1:0]    out_label_r;
  logic                  out_last_r;

  logic [NODE_W-1:0]     top_idx;
  logic [NODE_W-1:0]     cur;
  logic [GRAPH_SIDE-1:0] row;
  logic [NODE_COUNT-1:0] cand;
  logic [NODE_COUNT-1:0] first_hot;
  logic                  found;
  logic [NODE_W-1:0]     col;
  logic                  out_free;
  logic                  emit;
  logic                  emit_last;
  logic                  push_stack;

  assign top_idx   = NODE_W'(depth_r - 1'b1);
  assign cur       = stack_r[top_idx];
  assign row       = adj_row(adj, cur);
  assign cand      = row[NODE_COUNT-1:0] & ~visited_r;
  assign first_hot = cand & (~cand + 1'b1);
  assign found     = (cand != '0);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign req_pop   = !busy_r && req.valid;

  always_comb begin
    col = '0;
    for (int i = NODE_COUNT - 1; i >= 0; i--) begin
      if (cand[i]) col = NODE_W'(i);
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    visited_nxt   = visited_r;
    depth_nxt     = depth_r;
    pend_node_nxt = pend_node_r;
    emit          = 1'b0;
    emit_last     = 1'b0;
    push_stack    = 1'b0;
    if (!busy_r) begin
      if (req.valid) begin
        busy_nxt      = 1'b1;
        depth_nxt     = (NODE_W+1)'(1);
        pend_node_nxt = req.node;
        for (int i = 0; i < NODE_COUNT; i++) begin
          visited_nxt[i] = (req.node == NODE_W'(i));
        end
      end
    end else if (found) begin
      // descend: the held node is now known not to be the last of the walk
      if (out_free) begin
        emit          = 1'b1;
        push_stack    = 1'b1;
        visited_nxt   = visited_r | first_hot;
        pend_node_nxt = col;
        depth_nxt     = depth_r + 1'b1;
      end
    end else if (depth_r == (NODE_W+1)'(1)) begin
      if (out_free) begin
        emit      = 1'b1;
        emit_last = 1'b1;
        busy_nxt  = 1'b0;
        depth_nxt = '0;
      end
    end else begin
      depth_nxt = depth_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    visited_r   <= visited_nxt;
    pend_node_r <= pend_node_nxt;
    if (req_pop) begin
      stack_r[0] <= req.node;
    end else if (push_stack) begin
      stack_r[depth_r[NODE_W-1:0]] <= col;
    end
    if (emit) begin
      out_node_r  <= pend_node_r;
      out_label_r <= label_of(labels, pend_node_r);
      out_last_r  <= emit_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.node_index   = out_node_r;
  assign out_ch.node_label   = out_label_r;
  assign out_ch.last_of_walk = out_last_r;

endmodule

// ===== sv/adjacency_matrix_dfs_order_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_order_core
// Depth-first preorder of an 8-node directed graph held in two registers.
// ----------------------------------------------------------------------------
// usage:
//   cfg port writes register 0 (adjacency bits, row*8+col) and register 1
//   (one label byte per node); write only while no walk is in flight.
//   in_ch carries a start node per item; items wait in a two-entry queue.
//   out_ch returns one item per visited node in preorder (index and label),
//   last_of_walk set on the final one of each walk.
// sequence:
//   the walker loads a start node, then steps down or back over its node
//   stack, one descent or backtrack per step. the first item enters the
//   output register from the first step after the load; the final one
//   appears when the stack empties.
// reset:
//   queue, walker and output register empty; both config registers zero.
// stall:
//   a full output register holds the walker at its next emit; backtrack
//   steps go on meanwhile. the input queue still takes up to two starts.
// ----------------------------------------------------------------------------
module adjacency_matrix_dfs_order_core import adms_pkg::*; #(
  parameter int NODE_COUNT = NODE_COUNT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  adms_start_if.sink           in_ch,
  adms_result_if.source        out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0] adj_r;
  logic [CFG_W-1:0] labels_r;
  walk_req_t        walk_req;
  logic             walk_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adj_r    <= '0;
      labels_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ADJACENCY: adj_r    <= cfg_wdata;
        CFG_LABELS:    labels_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  adms_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .req_pop (walk_pop),
    .req     (walk_req)
  );

  adms_walk #(
    .NODE_COUNT (NODE_COUNT)
  ) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .adj     (adj_r),
    .labels  (labels_r),
    .req     (walk_req),
    .req_pop (walk_pop),
    .out_ch  (out_ch)
  );

`ifndef SYNTH
  a_pop_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    walk_pop |-> walk_req.valid)
    else $error("walker took a start from an empty queue");

  a_empty_queue_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !walk_req.valid |-> in_ch.ready)
    else $error("empty start queue refused an item");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");
`endif

endmodule
